// ===== sv/aavr_pkg.sv =====
// Shared types and constants for the axis-angle vector rotation pipeline.
package aavr_pkg;

	localparam int NCELL = 6;
	localparam int CELL_LAT = 3;

	localparam int ANG_FULL = 23040;
	localparam int ANG_QUARTER = 5760;
	localparam int ANG_EIGHTH = 2880;
	localparam int unsigned RAD_Q32 = 1171271;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	localparam int unsigned CDIV [NCELL] = '{132, 90, 56, 30, 12, 2};
	localparam int unsigned SDIV [NCELL] = '{0, 110, 72, 42, 20, 6};

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} quad_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] x2;
		logic [32:0] us;
		logic [32:0] uc;
		quad_t       quad;
		logic        swap;
	} trig_t;

endpackage

// ===== sv/aavr_cell.sv =====
// One series step cell: sine and cosine polynomial terms, three stages deep.
module aavr_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  aavr_pkg::trig_t din,
	output logic            out_vld,
	output aavr_pkg::trig_t dout
);
	import aavr_pkg::*;

	localparam int unsigned CD = CDIV[IDX];
	localparam int unsigned SD = SDIV[IDX];
	localparam int unsigned SDS = (SD == 0) ? 1 : SD;
	localparam logic [31:0] CM = 32'((64'd1 << 32) / CD);
	localparam logic [31:0] SM = 32'((64'd1 << 32) / SDS);

	logic        vld_s1, vld_s2, vld_s3;
	trig_t       t_s1, t_s2, t_s3;
	trig_t       t_nx;
	logic [31:0] ps_s1, pc_s1, ps_s2, pc_s2, es_s2, ec_s2;
	logic [31:0] rs, rc, qs, qc;
	logic [32:0] us_nx, uc_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		rs = ps_s2 - es_s2 * SDS;
		rc = pc_s2 - ec_s2 * CD;
		qs = es_s2 + 32'(rs >= SDS);
		qc = ec_s2 + 32'(rc >= CD);
		us_nx = (SD == 0) ? t_s2.us : (ONE_Q32 - 33'(qs));
		uc_nx = ONE_Q32 - 33'(qc);
		t_nx = t_s2;
		t_nx.us = us_nx;
		t_nx.uc = uc_nx;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= din;
			ps_s1 <= 32'((64'(din.x2) * 64'(din.us)) >> 32);
			pc_s1 <= 32'((64'(din.x2) * 64'(din.uc)) >> 32);
			t_s2 <= t_s1;
			ps_s2 <= ps_s1;
			pc_s2 <= pc_s1;
			es_s2 <= 32'((64'(ps_s1) * 64'(SM)) >> 32);
			ec_s2 <= 32'((64'(pc_s1) * 64'(CM)) >> 32);
			t_s3 <= t_nx;
		end
	end

	assign out_vld = vld_s3;
	assign dout = t_s3;

endmodule

// ===== sv/aavr_delay.sv =====
// Enabled delay line that carries axis and vector alongside the trig cells.
module aavr_delay #(
	parameter int W = 8,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

// ===== sv/axis_angle_vector_rotation.sv =====
// Top level: streaming axis-angle rotation of a 3-D fixed-point vector.
//
// Slave channel s_t*: one request per rotation, fields angle (1/64 degree),
// axis x/y/z (Q1.15) and vector x/y/z (Q16.16), all signed.
// Master channel m_t*: the rotated vector, rounded and saturated.
// The block takes one request per cycle while the output buffer has room;
// the sine/cosine series runs through a row of six step cells, three
// stages each, so every stage is occupied by its own item.
// The pipeline ends in a two-entry output buffer. When the receiver stalls,
// the buffer fills, s_tready falls and the whole pipeline holds; it resumes
// as soon as one entry drains. Reset clears all valid bits and the buffer,
// so nothing is presented until new requests arrive.
// s_tdata, lowest bit first: angle, axis_x, axis_y, axis_z, vec_x, vec_y,
// vec_z, zero fill. m_tdata: rot_x, rot_y, rot_z, zero fill.
module axis_angle_vector_rotation #(
	parameter int VECTOR_WIDTH = 32,
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// angle, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z
	input  logic [((64+3*VECTOR_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// rot_x, rot_y, rot_z
	output logic [((3*VECTOR_WIDTH+7)/8)*8-1:0] m_tdata
);
	import aavr_pkg::*;

	localparam int VW = VECTOR_WIDTH;
	localparam int F = TRIG_FRAC_BITS;
	localparam int OUT_W = ((3*VW+7)/8)*8;
	localparam int SH = 32 - F;
	localparam int SW = F + 2;
	localparam int CW = F + 3;
	localparam int MW = F + 4;
	localparam int PW = 32 + CW;
	localparam int AW = 16 + SW;
	localparam int EW = (VW > 25) ? VW : 25;
	localparam int HW = EW - 24;
	localparam int HPW = MW + HW;
	localparam int LPW = MW + 25;
	localparam int RW = EW + 8;
	localparam int SIDE_W = 48 + 3*VW;
	localparam int DLY = 3 + NCELL*CELL_LAT;

	localparam logic signed [16:0] FULL17 = 17'(ANG_FULL);
	localparam logic signed [CW-1:0] ONE_T = CW'(2**F);
	localparam logic signed [RW-1:0] VMAX = RW'({1'b0, {(VW-1){1'b1}}});
	localparam logic signed [RW-1:0] VMIN = -VMAX - RW'(1);

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;

	logic [14:0] ared_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [11:0] t_s2;
	quad_t quad_s2, quad_s3;
	logic swap_s2, swap_s3;
	logic [31:0] x_s3;
	trig_t trig_s4;

	logic signed [16:0] a17;
	logic [14:0] ared;
	logic [12:0] r2;
	logic [11:0] t2;
	quad_t q2;
	logic sw2;

	trig_t link [NCELL+1];
	logic lvld [NCELL+1];
	logic [SIDE_W-1:0] side_d;

	logic [31:0] sraw_s5;
	logic [32:0] craw_s5;
	quad_t quad_s5, quad_s6;
	logic swap_s5;
	logic [SIDE_W-1:0] side_s5, side_s6, side_s7;
	logic [33:0] srnd, crnd;
	logic [F:0] so_s6, co_s6;
	logic signed [SW-1:0] spos, cpos;
	logic signed [SW-1:0] sn_s7, cs_s7, sn_s8, cs_s8, cs_s9;
	logic signed [CW-1:0] c1_s7, c1_s8;
	logic signed [31:0] p_s8 [6];
	logic signed [15:0] axis_s8 [3];
	logic signed [VW-1:0] vec_s8 [3], vec_s9 [3], vec_s10 [3];
	logic signed [PW-1:0] symw [6];
	logic signed [AW-1:0] axsw [3];
	logic signed [MW-1:0] sym_s9 [6], axs_s9 [3];
	logic signed [MW-1:0] m_s10 [3][3];
	logic signed [EW-1:0] vext [3];
	logic signed [HPW-1:0] ph_s11 [3][3];
	logic signed [LPW-1:0] pl_s11 [3][3];
	logic signed [HPW+1:0] hs_s12 [3];
	logic signed [LPW+1:0] ls_s12 [3];
	logic signed [RW-1:0] r_s13 [3];
	logic [VW-1:0] sat [3];
	logic [OUT_W-1:0] push_d, head_q, tail_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign en = (cnt_q != 2'd2);
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= lvld[NCELL];
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	// reduce the angle to one turn, then fold to the first octant
	always_comb begin
		a17 = 17'(signed'(s_tdata[15:0]));
		if (a17 < -FULL17) begin
			ared = 15'(a17 + FULL17 + FULL17);
		end else if (a17 < 17'sd0) begin
			ared = 15'(a17 + FULL17);
		end else if (a17 >= FULL17) begin
			ared = 15'(a17 - FULL17);
		end else begin
			ared = 15'(a17);
		end
	end

	always_comb begin
		if (ared_s1 >= 15'(3*ANG_QUARTER)) begin
			q2 = QUAD_270;
			r2 = 13'(ared_s1 - 15'(3*ANG_QUARTER));
		end else if (ared_s1 >= 15'(2*ANG_QUARTER)) begin
			q2 = QUAD_180;
			r2 = 13'(ared_s1 - 15'(2*ANG_QUARTER));
		end else if (ared_s1 >= 15'(ANG_QUARTER)) begin
			q2 = QUAD_90;
			r2 = 13'(ared_s1 - 15'(ANG_QUARTER));
		end else begin
			q2 = QUAD_0;
			r2 = 13'(ared_s1);
		end
		if (r2 > 13'(ANG_EIGHTH)) begin
			t2 = 12'(13'(ANG_QUARTER) - r2);
			sw2 = 1'b1;
		end else begin
			t2 = 12'(r2);
			sw2 = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ared_s1 <= ared;
			side_s1 <= s_tdata[16 +: SIDE_W];
			t_s2 <= t2;
			quad_s2 <= q2;
			swap_s2 <= sw2;
			x_s3 <= 32'(t_s2) * RAD_Q32;
			quad_s3 <= quad_s2;
			swap_s3 <= swap_s2;
			trig_s4.x <= x_s3;
			trig_s4.x2 <= 32'((64'(x_s3) * 64'(x_s3)) >> 32);
			trig_s4.us <= ONE_Q32;
			trig_s4.uc <= ONE_Q32;
			trig_s4.quad <= quad_s3;
			trig_s4.swap <= swap_s3;
		end
	end

	assign link[0] = trig_s4;
	assign lvld[0] = vld_s4;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		aavr_cell #(
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_vld(lvld[i]),
			.din(link[i]),
			.out_vld(lvld[i+1]),
			.dout(link[i+1])
		);
	end

	aavr_delay #(
		.W(SIDE_W),
		.DEPTH(DLY)
	) u_side (
		.clk(clk),
		.en(en),
		.d(side_s1),
		.q(side_d)
	);

	// round the series to the trig fraction, then undo the fold and quadrant
	always_comb begin
		srnd = 34'(sraw_s5) + 34'(2**(SH-1));
		crnd = 34'(craw_s5) + 34'(2**(SH-1));
		spos = SW'(signed'({1'b0, so_s6}));
		cpos = SW'(signed'({1'b0, co_s6}));
	end

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			symw[i] = PW'(p_s8[i]) * PW'(c1_s8);
		end
		for (int k = 0; k < 3; k++) begin
			axsw[k] = AW'(axis_s8[k]) * AW'(sn_s8);
			vext[k] = EW'(vec_s10[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sraw_s5 <= 32'((64'(link[NCELL].x) * 64'(link[NCELL].us)) >> 32);
			craw_s5 <= link[NCELL].uc;
			quad_s5 <= link[NCELL].quad;
			swap_s5 <= link[NCELL].swap;
			side_s5 <= side_d;

			so_s6 <= swap_s5 ? crnd[SH +: F+1] : srnd[SH +: F+1];
			co_s6 <= swap_s5 ? srnd[SH +: F+1] : crnd[SH +: F+1];
			quad_s6 <= quad_s5;
			side_s6 <= side_s5;

			unique case (quad_s6)
				QUAD_0: begin
					sn_s7 <= spos;
					cs_s7 <= cpos;
					c1_s7 <= ONE_T - CW'(cpos);
				end
				QUAD_90: begin
					sn_s7 <= cpos;
					cs_s7 <= -spos;
					c1_s7 <= ONE_T + CW'(spos);
				end
				QUAD_180: begin
					sn_s7 <= -spos;
					cs_s7 <= -cpos;
					c1_s7 <= ONE_T + CW'(cpos);
				end
				default: begin
					sn_s7 <= -cpos;
					cs_s7 <= spos;
					c1_s7 <= ONE_T - CW'(spos);
				end
			endcase
			side_s7 <= side_s6;

			p_s8[0] <= signed'(side_s7[15:0]) * signed'(side_s7[15:0]);
			p_s8[1] <= signed'(side_s7[15:0]) * signed'(side_s7[31:16]);
			p_s8[2] <= signed'(side_s7[15:0]) * signed'(side_s7[47:32]);
			p_s8[3] <= signed'(side_s7[31:16]) * signed'(side_s7[31:16]);
			p_s8[4] <= signed'(side_s7[31:16]) * signed'(side_s7[47:32]);
			p_s8[5] <= signed'(side_s7[47:32]) * signed'(side_s7[47:32]);
			for (int k = 0; k < 3; k++) begin
				axis_s8[k] <= signed'(side_s7[16*k +: 16]);
				vec_s8[k] <= signed'(side_s7[48 + VW*k +: VW]);
			end
			sn_s8 <= sn_s7;
			cs_s8 <= cs_s7;
			c1_s8 <= c1_s7;

			for (int i = 0; i < 6; i++) begin
				sym_s9[i] <= MW'((symw[i] + PW'(2**29)) >>> 30);
			end
			for (int k = 0; k < 3; k++) begin
				axs_s9[k] <= MW'((axsw[k] + AW'(2**14)) >>> 15);
			end
			cs_s9 <= cs_s8;
			vec_s9 <= vec_s8;

			m_s10[0][0] <= sym_s9[0] + MW'(cs_s9);
			m_s10[0][1] <= sym_s9[1] - axs_s9[2];
			m_s10[0][2] <= sym_s9[2] + axs_s9[1];
			m_s10[1][0] <= sym_s9[1] + axs_s9[2];
			m_s10[1][1] <= sym_s9[3] + MW'(cs_s9);
			m_s10[1][2] <= sym_s9[4] - axs_s9[0];
			m_s10[2][0] <= sym_s9[2] - axs_s9[1];
			m_s10[2][1] <= sym_s9[4] + axs_s9[0];
			m_s10[2][2] <= sym_s9[5] + MW'(cs_s9);
			vec_s10 <= vec_s9;

			// split the vector into a signed high part and a 24-bit low part
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					ph_s11[r][k] <= HPW'(m_s10[r][k]) * HPW'(signed'(vext[k][EW-1:24]));
					pl_s11[r][k] <= LPW'(m_s10[r][k]) * LPW'(signed'({1'b0, vext[k][23:0]}));
				end
			end

			for (int r = 0; r < 3; r++) begin
				hs_s12[r] <= (HPW+2)'(ph_s11[r][0]) + (HPW+2)'(ph_s11[r][1])
					+ (HPW+2)'(ph_s11[r][2]);
				ls_s12[r] <= (LPW+2)'(pl_s11[r][0]) + (LPW+2)'(pl_s11[r][1])
					+ (LPW+2)'(pl_s11[r][2]);
			end

			for (int r = 0; r < 3; r++) begin
				r_s13[r] <= (RW'(hs_s12[r]) <<< (24 - F))
					+ RW'((ls_s12[r] + (LPW+2)'(2**(F-1))) >>> F);
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (r_s13[r] > VMAX) begin
				sat[r] = VW'(VMAX);
			end else if (r_s13[r] < VMIN) begin
				sat[r] = VW'(VMIN);
			end else begin
				sat[r] = VW'(r_s13[r]);
			end
		end
		push_d = OUT_W'({sat[2], sat[1], sat[0]});
		push = vld_s13 && en;
		pop = (cnt_q != 2'd0) && m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				head_q <= push_d;
			end else begin
				head_q <= tail_q;
				tail_q <= push_d;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_d;
			end else begin
				tail_q <= push_d;
			end
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata = head_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted request did not enter the pipeline");

	a_hold_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s13 && !en) |=> vld_s13)
		else $error("result lost while the pipeline was held");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1 && vld_s13 && en && !m_tready) |=> (cnt_q == 2'd2))
		else $error("output buffer did not take the result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !(vld_s13 && en)) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("output buffer did not drain");

endmodule

// ===== verif/axis_angle_vector_rotation_tb.sv =====
// Testbench for axis_angle_vector_rotation: directed table, random rotations, idles and stalls.
module axis_angle_vector_rotation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW = 32;
	localparam int TF = 16;
	localparam int N_RANDOM = 1500;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic signed [15:0] angle;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
		logic signed [VW-1:0] vz;
	} rot_req_t;

	typedef struct {
		logic [VW-1:0] rx;
		logic [VW-1:0] ry;
		logic [VW-1:0] rz;
	} rot_vec_t;

	typedef struct {
		rot_req_t req;
		bit       typed;
		rot_vec_t want;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [159:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [95:0] m_tdata;

	rot_vec_t rotated_q[$];
	dir_row_t dir_rows[$];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int cycles = 0;

	axis_angle_vector_rotation #(.VECTOR_WIDTH(VW), .TRIG_FRAC_BITS(TF)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic longint round_trig(bit [63:0] v);
		return longint'((v + (64'd1 << (31 - TF))) >> (32 - TF));
	endfunction

	function automatic longint round_shift(longint x, int sh);
		return (x + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic void octant_sincos(longint t, output longint sn, output longint cs);
		int unsigned sdiv[5] = '{110, 72, 42, 20, 6};
		int unsigned cdiv[6] = '{132, 90, 56, 30, 12, 2};
		bit [63:0] x, x2, u;
		x = 64'(t) * 64'd1171271;
		x2 = (x * x) >> 32;
		u = 64'd1 << 32;
		for (int i = 0; i < 5; i++)
			u = (64'd1 << 32) - ((x2 * u) >> 32) / sdiv[i];
		sn = round_trig((x * u) >> 32);
		u = 64'd1 << 32;
		for (int i = 0; i < 6; i++)
			u = (64'd1 << 32) - ((x2 * u) >> 32) / cdiv[i];
		cs = round_trig(u);
	endfunction

	function automatic void angle_sincos(longint ang, output longint sn, output longint cs);
		longint a, r, s0, c0;
		int q;
		a = ang % 23040;
		if (a < 0)
			a += 23040;
		q = a / 5760;
		r = a % 5760;
		if (r <= 2880)
			octant_sincos(r, s0, c0);
		else
			octant_sincos(5760 - r, c0, s0);
		case (q)
			0: begin sn = s0; cs = c0; end
			1: begin sn = c0; cs = -s0; end
			2: begin sn = -s0; cs = -c0; end
			default: begin sn = -c0; cs = s0; end
		endcase
	endfunction

	function automatic logic [VW-1:0] row_dot(longint m0, longint m1, longint m2,
			longint v0, longint v1, longint v2);
		longint m[3], v[3], hi, lo, r, lim;
		m = '{m0, m1, m2};
		v = '{v0, v1, v2};
		hi = 0;
		lo = 0;
		for (int k = 0; k < 3; k++) begin
			hi += m[k] * (v[k] >>> 24);
			lo += m[k] * (v[k] & 64'hFF_FFFF);
		end
		r = hi * (longint'(1) << (24 - TF)) + round_shift(lo, TF);
		lim = (longint'(1) << (VW - 1)) - 1;
		if (r > lim)
			r = lim;
		if (r < -lim - 1)
			r = -lim - 1;
		return r[VW-1:0];
	endfunction

	function automatic rot_vec_t rotate(rot_req_t q);
		longint sn, cs, c1, ax, ay, az, vx, vy, vz;
		longint sxx, syy, szz, sxy, sxz, syz, tx, ty, tz;
		rot_vec_t o;
		ax = q.ax;
		ay = q.ay;
		az = q.az;
		vx = q.vx;
		vy = q.vy;
		vz = q.vz;
		angle_sincos(longint'(q.angle), sn, cs);
		c1 = (longint'(1) << TF) - cs;
		sxx = round_shift(ax * ax * c1, 30);
		syy = round_shift(ay * ay * c1, 30);
		szz = round_shift(az * az * c1, 30);
		sxy = round_shift(ax * ay * c1, 30);
		sxz = round_shift(ax * az * c1, 30);
		syz = round_shift(ay * az * c1, 30);
		tx = round_shift(ax * sn, 15);
		ty = round_shift(ay * sn, 15);
		tz = round_shift(az * sn, 15);
		o.rx = row_dot(sxx + cs, sxy - tz, sxz + ty, vx, vy, vz);
		o.ry = row_dot(sxy + tz, syy + cs, syz - tx, vx, vy, vz);
		o.rz = row_dot(sxz - ty, syz + tx, szz + cs, vx, vy, vz);
		return o;
	endfunction

	function automatic rot_req_t random_req();
		rot_req_t q;
		if (chance(85))
			q.angle = 16'($signed($urandom_range(0, 46080)) - 23040);
		else
			q.angle = 16'($urandom);
		q.ax = 16'($urandom);
		q.ay = 16'($urandom);
		q.az = 16'($urandom);
		if (chance(30)) begin
			q.vx = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			q.vy = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			q.vz = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		end else begin
			q.vx = $urandom;
			q.vy = $urandom;
			q.vz = $urandom;
		end
		return q;
	endfunction

	task automatic send(rot_req_t q, bit typed, rot_vec_t want);
		s_tdata <= {q.vz, q.vy, q.vx, q.az, q.ay, q.ax, q.angle};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		rotated_q.push_back(typed ? want : rotate(q));
		n_sent++;
		while (chance(send_idle_pct)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (rotated_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk)
		if (arst_n)
			m_tready <= !chance(stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t, %0d results outstanding", $time, rotated_q.size());
			$display("axis_angle_vector_rotation_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		rot_vec_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.rx = m_tdata[31:0];
			got.ry = m_tdata[63:32];
			got.rz = m_tdata[95:64];
			if (rotated_q.size() == 0) begin
				$display("%0t: unexpected result %h %h %h", $time, got.rx, got.ry, got.rz);
				errors++;
			end else begin
				want = rotated_q.pop_front();
				n_checked++;
				if (got.rx !== want.rx) begin
					$display("%0t: rot_x expected %h got %h", $time, want.rx, got.rx);
					errors++;
				end
				if (got.ry !== want.ry) begin
					$display("%0t: rot_y expected %h got %h", $time, want.ry, got.ry);
					errors++;
				end
				if (got.rz !== want.rz) begin
					$display("%0t: rot_z expected %h got %h", $time, want.rz, got.rz);
					errors++;
				end
			end
		end
	end

	initial begin
		rot_vec_t none;
		int idle_set[4] = '{0, 76, 0, 13};
		int stall_set[4] = '{0, 0, 76, 13};
		none = '{default: '0};
		// zero and full-turn angles leave any vector unchanged
		dir_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 32'sh10000, 32'sd0, 32'sd0},
			1, '{32'h10000, 32'h0, 32'h0}});
		dir_rows.push_back('{'{16'sd0, -16'sd32768, -16'sd32768, -16'sd32768,
			32'sh7FFFFFFF, 32'sh80000000, 32'sd0},
			1, '{32'h7FFFFFFF, 32'h80000000, 32'h0}});
		dir_rows.push_back('{'{16'sd23040, 16'sd32767, 16'sd0, 16'sd0,
			32'sh80000000, 32'sh7FFFFFFF, -32'sd1},
			1, '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF}});
		dir_rows.push_back('{'{-16'sd23040, 16'sd0, 16'sd32767, 16'sd0,
			32'sh12345678, -32'sd1, 32'sd1},
			1, '{32'h12345678, 32'hFFFFFFFF, 32'h1}});
		dir_rows.push_back('{'{16'sd5760, 16'sd0, 16'sd0, 16'sd32767, 32'sh10000, 32'sd0, 32'sd0},
			0, none});
		dir_rows.push_back('{'{16'sd11520, 16'sd32767, 16'sd0, 16'sd0, 32'sh10000, 32'sh20000,
			32'sh30000}, 0, none});
		dir_rows.push_back('{'{-16'sd5760, 16'sd0, 16'sd32767, 16'sd0, 32'sh10000, 32'sh10000,
			32'sh10000}, 0, none});
		dir_rows.push_back('{'{16'sd2880, 16'sd18919, 16'sd18919, 16'sd18918, 32'sh10000,
			-32'sh10000, 32'sh8000}, 0, none});
		dir_rows.push_back('{'{16'sd2879, 16'sd0, 16'sd0, -16'sd32767, 32'sh7FFFFFFF, 32'sd0,
			32'sd0}, 0, none});
		dir_rows.push_back('{'{16'sd2881, 16'sd0, 16'sd0, -16'sd32767, 32'sh7FFFFFFF, 32'sd0,
			32'sd0}, 0, none});
		dir_rows.push_back('{'{16'sd1, 16'sd32767, 16'sd0, 16'sd0, 32'sd0, 32'sh10000, 32'sd0},
			0, none});
		dir_rows.push_back('{'{16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 32'sh10000, 32'sh10000,
			32'sd0}, 0, none});
		dir_rows.push_back('{'{-16'sd32768, 16'sd0, 16'sd0, 16'sd32767, 32'sh10000, 32'sh10000,
			32'sd0}, 0, none});
		dir_rows.push_back('{'{16'sd17280, -16'sd32768, 16'sd0, 16'sd0, 32'sh10000, 32'sh20000,
			32'sh30000}, 0, none});
		dir_rows.push_back('{'{16'sd11520, 16'sd32767, 16'sd32767, 16'sd32767, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 32'sh7FFFFFFF}, 0, none});
		dir_rows.push_back('{'{16'sd7000, 16'sd32767, -16'sd32767, 16'sd32767, 32'sh80000000,
			32'sh80000000, 32'sh7FFFFFFF}, 0, none});
		dir_rows.push_back('{'{16'sd4000, 16'sd10000, 16'sd5000, -16'sd20000, 32'sd0, 32'sd0,
			32'sd0}, 0, none});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			for (int i = 0; i < N_RANDOM / 4; i++) begin
				if (p == 0 && i == 100)
					wait_drained();
				send(random_req(), 0, none);
			end
			wait_drained();
		end
		send_idle_pct = 0;
		stall_pct = 0;
		s_tvalid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d rotations (%0d directed), checked %0d results", n_sent,
			dir_rows.size(), n_checked);
		$display("phases: free flow, sender idle, receiver stall, mixed; %0d mismatches", errors);
		if (errors == 0 && rotated_q.size() == 0)
			$display("axis_angle_vector_rotation_tb passed");
		else
			$display("axis_angle_vector_rotation_tb failed");
		$finish;
	end
endmodule
